// ----- sv/plf_pkg.sv -----
// Package for the polyline length fare block: widths, item types, states, register map.
package plf_pkg;

  // Coordinate format
  localparam int COORD_W = 24;
  localparam int FRAC_W  = 8;

  // Segment length: |dx| and |dy| fit COORD_W bits, the root fits one more
  localparam int DIFF_W = COORD_W;
  localparam int ROOT_W = COORD_W + 1;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int CNT_W  = $clog2(ROOT_W);

  // Accumulated length and price
  localparam int SUM_W   = 40;
  localparam int PRICE_W = 48;
  localparam int UNIT_W  = 16;
  localparam logic [UNIT_W-1:0]  UNIT_PRICE_RESET = 16'd384;
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

  // Shared multiplier operand widths
  localparam int MA_W   = (SUM_W > DIFF_W) ? SUM_W : DIFF_W;
  localparam int MB_W   = (UNIT_W > DIFF_W) ? UNIT_W : DIFF_W;
  localparam int PROD_W = MA_W + MB_W;
  localparam int PFULL_W = PROD_W - FRAC_W;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_UNIT_PRICE = 3'd0;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      path_end;
  } in_item_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_ACC,
    ST_UPD,
    ST_PRICE
  } state_t;

endpackage

// ----- sv/polyline_length_fare_top.sv -----
// Polyline length fare: point stream in, path price out, over a shared multiplier and root unit.
//
//  channel  | ports                                   | payload
//  ---------+-----------------------------------------+----------------------------
//  input    | in_valid, in_ready, in_data             | point_x, point_y, path_end
//  result   | out_valid, out_ready, out_data          | price, saturated
//  config   | psel, penable, pwrite, paddr, pwdata,   | unit_price at address 0
//           | prdata, pready                          |
//
// A point that closes a segment goes through accept, two squaring passes on the shared multiplier,
// one root bit per cycle, accumulate and update. The first point of a path goes from accept
// straight to update, or to pricing if it ends the path. A final point ends by pricing
// on the same multiplier instead of updating, held there while an earlier result
// is still not taken. in_ready is high only while the sequencer is idle. Reset is
// synchronous, active low, and restores unit_price to 1.5 and clears the path state.
module polyline_length_fare_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  plf_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output plf_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plf_pkg::APB_AW-1:0]  paddr,
  input  logic [plf_pkg::APB_DW-1:0]  pwdata,
  output logic [plf_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  plf_pkg::state_t state_r, state_nxt;

  // Configuration
  logic [plf_pkg::UNIT_W-1:0] unit_price_r, unit_price_nxt;

  // Path state
  logic [plf_pkg::COORD_W-1:0] prev_x_r, prev_x_nxt;
  logic [plf_pkg::COORD_W-1:0] prev_y_r, prev_y_nxt;
  logic                        have_prev_r, have_prev_nxt;
  logic [plf_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic                        clipped_r, clipped_nxt;

  // Working registers of the current item
  logic [plf_pkg::COORD_W-1:0] x_r, x_nxt;
  logic [plf_pkg::COORD_W-1:0] y_r, y_nxt;
  logic                        last_r, last_nxt;
  logic [plf_pkg::DIFF_W-1:0]  dx_r, dx_nxt;
  logic [plf_pkg::DIFF_W-1:0]  dy_r, dy_nxt;
  logic [plf_pkg::RAD_W-1:0]   rad_r, rad_nxt;
  logic [plf_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [plf_pkg::ROOT_W-1:0]  root_r, root_nxt;
  logic [plf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  plf_pkg::out_item_t   out_data_r, out_data_nxt;

  // Combinational helpers
  logic                        in_fire;
  logic                        cfg_wr;
  logic                        root_done;
  logic                        out_free;
  logic [plf_pkg::COORD_W:0]   dsx, dsy;
  logic [plf_pkg::COORD_W:0]   adx, ady;
  logic [plf_pkg::MA_W-1:0]    mult_a;
  logic [plf_pkg::MB_W-1:0]    mult_b;
  logic [plf_pkg::PROD_W-1:0]  prod;
  logic [plf_pkg::REM_W-1:0]   rem_sh;
  logic [plf_pkg::REM_W-1:0]   trial;
  logic [plf_pkg::SUM_W:0]     sum_ext;
  logic [plf_pkg::PFULL_W-1:0] price_full;

  assign in_ready  = (state_r == plf_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign root_done = (cnt_r == plf_pkg::CNT_W'(plf_pkg::ROOT_W - 1));

  // APB access: always ready, single register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr)
      plf_pkg::ADDR_UNIT_PRICE: prdata = plf_pkg::APB_DW'(unit_price_r);
      default:                  prdata = '0;
    endcase
  end

  // Absolute coordinate differences against the held point
  assign dsx = {in_data.point_x[plf_pkg::COORD_W-1], in_data.point_x}
             - {prev_x_r[plf_pkg::COORD_W-1], prev_x_r};
  assign dsy = {in_data.point_y[plf_pkg::COORD_W-1], in_data.point_y}
             - {prev_y_r[plf_pkg::COORD_W-1], prev_y_r};
  assign adx = dsx[plf_pkg::COORD_W] ? (~dsx + 1'b1) : dsx;
  assign ady = dsy[plf_pkg::COORD_W] ? (~dsy + 1'b1) : dsy;

  // Shared multiplier: squares of dx and dy, then length times unit price
  always_comb begin
    case (state_r)
      plf_pkg::ST_SQX: begin
        mult_a = plf_pkg::MA_W'(dx_r);
        mult_b = plf_pkg::MB_W'(dx_r);
      end
      plf_pkg::ST_SQY: begin
        mult_a = plf_pkg::MA_W'(dy_r);
        mult_b = plf_pkg::MB_W'(dy_r);
      end
      default: begin
        mult_a = plf_pkg::MA_W'(sum_r);
        mult_b = plf_pkg::MB_W'(unit_price_r);
      end
    endcase
  end
  assign prod = plf_pkg::PROD_W'(mult_a) * plf_pkg::PROD_W'(mult_b);

  // Root step: bring down the next radicand bit pair, try the subtraction
  assign rem_sh = {rem_r[plf_pkg::REM_W-3:0], rad_r[plf_pkg::RAD_W-1 -: 2]};
  assign trial  = plf_pkg::REM_W'({root_r, 2'b01});

  // Saturating accumulate and price scaling
  assign sum_ext    = {1'b0, sum_r} + (plf_pkg::SUM_W + 1)'(root_r);
  assign price_full = prod[plf_pkg::PROD_W-1:plf_pkg::FRAC_W];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plf_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (have_prev_r)           state_nxt = plf_pkg::ST_SQX;
          else if (in_data.path_end) state_nxt = plf_pkg::ST_PRICE;
          else                       state_nxt = plf_pkg::ST_UPD;
        end
      end
      plf_pkg::ST_SQX:  state_nxt = plf_pkg::ST_SQY;
      plf_pkg::ST_SQY:  state_nxt = plf_pkg::ST_ROOT;
      plf_pkg::ST_ROOT: if (root_done) state_nxt = plf_pkg::ST_ACC;
      plf_pkg::ST_ACC:  state_nxt = last_r ? plf_pkg::ST_PRICE : plf_pkg::ST_UPD;
      plf_pkg::ST_UPD:  state_nxt = plf_pkg::ST_IDLE;
      plf_pkg::ST_PRICE: if (out_free) state_nxt = plf_pkg::ST_IDLE;
      default:          state_nxt = plf_pkg::ST_IDLE;
    endcase
  end

  // Datapath next values per state
  always_comb begin
    unit_price_nxt = unit_price_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    have_prev_nxt  = have_prev_r;
    sum_nxt        = sum_r;
    clipped_nxt    = clipped_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    last_nxt       = last_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    rad_nxt        = rad_r;
    rem_nxt        = rem_r;
    root_nxt       = root_r;
    cnt_nxt        = cnt_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    // Take a register write
    if (cfg_wr && (paddr == plf_pkg::ADDR_UNIT_PRICE)) begin
      unit_price_nxt = pwdata[plf_pkg::UNIT_W-1:0];
    end

    case (state_r)
      plf_pkg::ST_IDLE: begin
        // Latch the item and its differences
        if (in_fire) begin
          x_nxt    = in_data.point_x;
          y_nxt    = in_data.point_y;
          last_nxt = in_data.path_end;
          dx_nxt   = adx[plf_pkg::DIFF_W-1:0];
          dy_nxt   = ady[plf_pkg::DIFF_W-1:0];
        end
      end
      plf_pkg::ST_SQX: begin
        rad_nxt = plf_pkg::RAD_W'(prod[2*plf_pkg::DIFF_W-1:0]);
      end
      plf_pkg::ST_SQY: begin
        // Add the second square and arm the root unit
        rad_nxt  = rad_r + plf_pkg::RAD_W'(prod[2*plf_pkg::DIFF_W-1:0]);
        rem_nxt  = '0;
        root_nxt = '0;
        cnt_nxt  = '0;
      end
      plf_pkg::ST_ROOT: begin
        // One root bit per cycle
        rad_nxt = {rad_r[plf_pkg::RAD_W-3:0], 2'b00};
        cnt_nxt = cnt_r + 1'b1;
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[plf_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[plf_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      plf_pkg::ST_ACC: begin
        // Add the segment, stick at the ceiling
        if (sum_ext[plf_pkg::SUM_W]) begin
          sum_nxt     = plf_pkg::SUM_MAX;
          clipped_nxt = 1'b1;
        end else begin
          sum_nxt = sum_ext[plf_pkg::SUM_W-1:0];
        end
      end
      plf_pkg::ST_UPD: begin
        prev_x_nxt    = x_r;
        prev_y_nxt    = y_r;
        have_prev_nxt = 1'b1;
      end
      plf_pkg::ST_PRICE: begin
        // Emit the price once the result register is free, then clear the path
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (|price_full[plf_pkg::PFULL_W-1:plf_pkg::PRICE_W]) begin
            out_data_nxt.price     = plf_pkg::PRICE_MAX;
            out_data_nxt.saturated = 1'b1;
          end else begin
            out_data_nxt.price     = price_full[plf_pkg::PRICE_W-1:0];
            out_data_nxt.saturated = clipped_r;
          end
          prev_x_nxt    = '0;
          prev_y_nxt    = '0;
          have_prev_nxt = 1'b0;
          sum_nxt       = '0;
          clipped_nxt   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= plf_pkg::ST_IDLE;
      unit_price_r <= plf_pkg::UNIT_PRICE_RESET;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      have_prev_r  <= 1'b0;
      sum_r        <= '0;
      clipped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      unit_price_r <= unit_price_nxt;
      prev_x_r     <= prev_x_nxt;
      prev_y_r     <= prev_y_nxt;
      have_prev_r  <= have_prev_nxt;
      sum_r        <= sum_nxt;
      clipped_r    <= clipped_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    last_r     <= last_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- sv/plf_checker.sv -----
// Port-level checker for the polyline length fare block, with its bind.
module plf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input plf_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input plf_pkg::out_item_t out_data
);

  // Out of reset the block is idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // Every accepted item leaves the sequencer busy in the cycle after its acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted in back-to-back cycles");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before it was taken");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("result payload changed while stalled");

endmodule

bind polyline_length_fare_top plf_checker u_plf_checker (.*);

// ----- verif/plf_fare_checker.sv -----
// Scoreboard for the polyline length fare block: predicts path prices and checks every result item.
module plf_fare_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  plf_pkg::in_item_t          in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  plf_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [plf_pkg::APB_AW-1:0] paddr,
  input  logic [plf_pkg::APB_DW-1:0] pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         pending_count,
  output int                         prices_checked,
  output int                         clipped_paths
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the register and of the path state
  logic [plf_pkg::UNIT_W-1:0]         fare_unit;
  logic signed [plf_pkg::COORD_W-1:0] last_x;
  logic signed [plf_pkg::COORD_W-1:0] last_y;
  logic                               have_last;
  logic [plf_pkg::SUM_W-1:0]          dist_sum;
  logic                               dist_clipped;
  plf_pkg::out_item_t                 fare_queue[$];
  int                                 fails;
  int                                 checked;
  int                                 clipped;

  // Floor square root, one result bit per pass over two radicand bits
  function automatic logic [plf_pkg::ROOT_W-1:0] floor_root(input logic [63:0] rad);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] trial;
    rem  = '0;
    root = '0;
    for (int i = plf_pkg::ROOT_W - 1; i >= 0; i--) begin
      rem   = (rem << 2) | ((rad >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      root  = root << 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = root | 64'd1;
      end
    end
    return root[plf_pkg::ROOT_W-1:0];
  endfunction

  // Euclidean distance between two points, floored, same fraction bits as the coordinates
  function automatic logic [plf_pkg::ROOT_W-1:0] segment_len(
    input logic signed [plf_pkg::COORD_W-1:0] ax,
    input logic signed [plf_pkg::COORD_W-1:0] ay,
    input logic signed [plf_pkg::COORD_W-1:0] bx,
    input logic signed [plf_pkg::COORD_W-1:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return floor_root(64'(dx * dx + dy * dy));
  endfunction

  always @(posedge clk) begin
    logic [plf_pkg::ROOT_W-1:0] seg;
    logic [63:0]                wide;
    plf_pkg::out_item_t         want;
    plf_pkg::out_item_t         got;
    if (!rst_n) begin
      fare_unit    = plf_pkg::UNIT_PRICE_RESET;
      last_x       = '0;
      last_y       = '0;
      have_last    = 1'b0;
      dist_sum     = '0;
      dist_clipped = 1'b0;
      fare_queue.delete();
      fails   = 0;
      checked = 0;
      clipped = 0;
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready && paddr == plf_pkg::ADDR_UNIT_PRICE)
        fare_unit = pwdata[plf_pkg::UNIT_W-1:0];

      // Compare a taken result item against the oldest prediction
      if (out_valid && out_ready) begin
        got = out_data;
        if (fare_queue.size() == 0) begin
          $error("result item with none predicted: price %0d saturated %0b",
                 got.price, got.saturated);
          fails++;
        end else begin
          want = fare_queue.pop_front();
          checked++;
          if (got.price !== want.price) begin
            $error("price: expected %0d, got %0d", want.price, got.price);
            fails++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
            fails++;
          end
        end
      end

      // Advance the path on an accepted point
      if (in_valid && in_ready) begin
        if (have_last) begin
          seg = segment_len(in_data.point_x, in_data.point_y, last_x, last_y);
          if (64'(seg) > 64'(plf_pkg::SUM_MAX) - 64'(dist_sum)) begin
            dist_sum     = plf_pkg::SUM_MAX;
            dist_clipped = 1'b1;
          end else begin
            dist_sum = dist_sum + plf_pkg::SUM_W'(seg);
          end
        end
        if (in_data.path_end) begin
          // Price the path, then start over
          wide           = (64'(dist_sum) * 64'(fare_unit)) >> plf_pkg::FRAC_W;
          want.saturated = dist_clipped;
          if (wide > 64'(plf_pkg::PRICE_MAX)) begin
            wide           = 64'(plf_pkg::PRICE_MAX);
            want.saturated = 1'b1;
          end
          want.price = wide[plf_pkg::PRICE_W-1:0];
          fare_queue.push_back(want);
          if (want.saturated) clipped++;
          last_x       = '0;
          last_y       = '0;
          have_last    = 1'b0;
          dist_sum     = '0;
          dist_clipped = 1'b0;
        end else begin
          last_x    = in_data.point_x;
          last_y    = in_data.point_y;
          have_last = 1'b1;
        end
      end
    end
    fail_count     <= fails;
    pending_count  <= fare_queue.size();
    prices_checked <= checked;
    clipped_paths  <= clipped;
  end

endmodule

// ----- verif/tb_top.sv -----
// Top of the polyline length fare testbench: clock, reset, point stimulus, register writes, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = plf_pkg::COORD_W;
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [plf_pkg::APB_AW-1:0] ADDR_SPARE = 3'd4;
  localparam int PHASE_ITEMS      = 430;
  localparam int SETTLE_CYCLES    = 48;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT   = 5000;
  // Maximal diagonal segments back and forth in one long path
  localparam int ZIGZAG_POINTS    = 24;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  plf_pkg::in_item_t          in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  plf_pkg::out_item_t         out_data;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [plf_pkg::APB_AW-1:0] paddr = '0;
  logic [plf_pkg::APB_DW-1:0] pwdata = '0;
  logic [plf_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  int fail_count;
  int pending_count;
  int prices_checked;
  int clipped_paths;
  int send_idle_pct = 11;
  int recv_idle_pct = 69;
  int holds_asked = 0;
  int holds_done = 0;
  int points_sent = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  polyline_length_fare_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  plf_fare_checker fare_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .prices_checked (prices_checked),
    .clipped_paths  (clipped_paths)
  );

  // Drop the result side at random; serve a long hold-off when one is asked for
  initial begin
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)))
      quiet_cycles <= quiet_cycles + 1;
    else
      quiet_cycles <= 0;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("tb_top: errors");
      $finish;
    end
  end

  // Offer one point after a random gap and hold it until taken
  task automatic send_point(input logic signed [CW-1:0] x,
                            input logic signed [CW-1:0] y,
                            input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= '{point_x: x, point_y: y, path_end: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    points_sent++;
  endtask

  // Stop offering, wait out every predicted price, then let a segment finish
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic cfg_write(input logic [plf_pkg::APB_AW-1:0] addr,
                           input logic [plf_pkg::APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3:    return CW'(int'($urandom_range(4095)) - 2048);
      default: return CW'($urandom());
    endcase
  endfunction

  // Mostly short paths with random points, some single points and some long runs
  task automatic run_paths(input int item_goal);
    int sent_here;
    int points;
    sent_here = 0;
    while (sent_here < item_goal) begin
      case ($urandom_range(19))
        0, 1, 2: points = 1;
        3:       points = $urandom_range(12, 24);
        default: points = $urandom_range(2, 6);
      endcase
      for (int k = 0; k < points; k++) begin
        send_point(pick_coord(), pick_coord(), k == points - 1);
        sent_here++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed paths at the reset unit price
    send_point(CW'(0), CW'(0), 1'b1);
    send_point(COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MIN, 1'b1);
    send_point(COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 1'b1);
    send_point(CW'(5), CW'(5), 1'b0);
    send_point(CW'(5), CW'(5), 1'b1);
    send_point(CW'(0), CW'(0), 1'b0);
    send_point(CW'(768), CW'(1024), 1'b1);
    send_point(CW'(0), CW'(0), 1'b0);
    send_point(CW'(256), CW'(0), 1'b0);
    send_point(CW'(256), CW'(-256), 1'b0);
    send_point(CW'(-1), CW'(-1), 1'b1);
    send_point(COORD_MIN, COORD_MIN, 1'b1);
    send_point(CW'(-1), COORD_MAX, 1'b0);
    send_point(CW'(1), COORD_MIN, 1'b1);
    drain_block();

    // Spare address must be ignored; top price with junk above the field
    cfg_write(ADDR_SPARE, 32'h0000_0001);
    send_point(CW'(0), CW'(0), 1'b0);
    send_point(CW'(256), CW'(0), 1'b1);
    drain_block();
    cfg_write(plf_pkg::ADDR_UNIT_PRICE, 32'hA5C3_FFFF);
    run_paths(PHASE_ITEMS);
    drain_block();

    // Free rides, receiver mostly ready
    cfg_write(plf_pkg::ADDR_UNIT_PRICE, 32'hFFFF_0000);
    send_idle_pct = 69;
    recv_idle_pct <= 11;
    run_paths(PHASE_ITEMS);
    drain_block();

    // No idling; fill the block behind a long receiver hold-off first
    cfg_write(plf_pkg::ADDR_UNIT_PRICE, {16'($urandom()), 16'($urandom_range(1, 65534))});
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    holds_asked <= holds_asked + 1;
    for (int k = 0; k < 12; k++) send_point(pick_coord(), pick_coord(), 1'b1);
    send_point(pick_coord(), pick_coord(), 1'b0);
    send_point(pick_coord(), pick_coord(), 1'b1);
    run_paths(PHASE_ITEMS);
    drain_block();

    // One long zig-zag path of maximal diagonal segments at the top price, then a fresh path
    cfg_write(plf_pkg::ADDR_UNIT_PRICE, 32'h0000_FFFF);
    for (int k = 0; k < ZIGZAG_POINTS; k++)
      send_point(k[0] ? COORD_MAX : COORD_MIN, k[0] ? COORD_MAX : COORD_MIN,
                 k == ZIGZAG_POINTS - 1);
    send_point(CW'(0), CW'(0), 1'b0);
    send_point(CW'(768), CW'(1024), 1'b1);
    drain_block();

    $display("run: %0d points sent, %0d path prices checked, %0d flagged saturated",
             points_sent, prices_checked, clipped_paths);
    $display("run: unit price at reset value, 0, 0xFFFF and random; long result hold-off");
    if (fail_count == 0 && pending_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
